@@ rtl/searchable_bounded_fifo_assert.svh @@
// assertion macros used by the searchable fifo top level
`ifndef SEARCHABLE_BOUNDED_FIFO_ASSERT_SVH
`define SEARCHABLE_BOUNDED_FIFO_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define SBF_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sbf assertion failed");

// next-cycle implication, sampled on clock, off during reset
`define SBF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sbf assertion failed");

`endif

@@ rtl/sbf_pkg.sv @@
// package: sizes, codes, ram write type and slot step functions for the searchable fifo
package sbf_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CAP_W = 5;
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic [1:0] CMD_QUERY = 2'd0;
   localparam logic [1:0] CMD_ENQ   = 2'd1;
   localparam logic [1:0] CMD_DEQ   = 2'd2;
   localparam logic [1:0] CMD_REPL  = 2'd3;

   localparam logic [1:0] STS_DONE  = 2'd0;
   localparam logic [1:0] STS_FULL  = 2'd1;
   localparam logic [1:0] STS_EMPTY = 2'd2;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [7:0]       data;
   } ram_wr_type;

   function automatic logic [IDX_W-1:0] slot_next(input logic [IDX_W-1:0] i);
      return (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] slot_prev(input logic [IDX_W-1:0] i);
      return (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
   endfunction

endpackage

@@ rtl/sbf_ram.sv @@
// entry store: one write port, one registered read port
module sbf_ram (
   input  logic                    clock,
   input  sbf_pkg::ram_wr_type     wr,
   input  logic                    rd_en,
   input  logic [sbf_pkg::IDX_W-1:0] rd_addr,
   output logic [7:0]              rd_data
);
   import sbf_pkg::*;

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/searchable_bounded_fifo.sv @@
// top level: byte fifo with programmable capacity and serial key search
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_ready  req_command, req_data
//   rsp_      out        rsp_valid/rsp_ready  rsp_status, rsp_front_valid,
//                                             rsp_front_data, rsp_occupancy,
//                                             rsp_full_flag, rsp_key_found
//   csr_      in         csr_wr_en            csr_wr_data (capacity)
//
// a word passes from accept to the next ready through an accept step in idle, a
// search that reads each stored entry through the single ram read port into the
// one byte comparator, and an update step that writes the store and loads rsp.
// synchronous active-high reset clears pointers, count and control; capacity
// resets to 16. the result register lets the next word be taken while a
// result waits; a stalled rsp only holds the update cycle.
module searchable_bounded_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_command,
   input  logic [7:0]                req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_status,
   output logic                      rsp_front_valid,
   output logic [7:0]                rsp_front_data,
   output logic [4:0]                rsp_occupancy,
   output logic                      rsp_full_flag,
   output logic                      rsp_key_found,
   input  logic                      csr_wr_en,
   input  logic [sbf_pkg::CAP_W-1:0] csr_wr_data
);
   import sbf_pkg::*;

   // sequencer states
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CAP_W-1:0] cap_ff;

   // latched word and search progress
   logic [1:0]       cmd_ff, cmd_in;
   logic [7:0]       key_ff, key_in;
   logic             full_ff, full_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] iss_ff, iss_in;
   logic             pend_ff, pend_in;
   logic             first_ff, first_in;
   logic             found_ff, found_in;
   logic [7:0]       front_ff, front_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic             rsp_fvalid_ff, rsp_fvalid_in;
   logic [7:0]       rsp_fdata_ff, rsp_fdata_in;
   logic [4:0]       rsp_occ_ff, rsp_occ_in;
   logic             rsp_full_ff, rsp_full_in;
   logic             rsp_found_ff, rsp_found_in;

   // ram side
   ram_wr_type       ram_wr;
   logic             rd_en;
   logic [7:0]       rd_data;

   logic [CMP_W-1:0] cap_ext;
   logic [CMP_W-1:0] eff_cap;
   logic             full_now;
   logic             nonempty;
   logic             out_free;
   logic [1:0]       status;
   logic             do_write;

   sbf_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_en   (rd_en),
      .rd_addr (pos_ff),
      .rd_data (rd_data)
   );

   // capacity above depth clamps to depth; zero means always full
   assign cap_ext  = CMP_W'(cap_ff);
   assign eff_cap  = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
   assign full_now = CMP_W'(count_ff) >= eff_cap;
   assign nonempty = count_ff != '0;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign req_ready = (state_ff == ST_IDLE);
   assign rd_en     = (state_ff == ST_SEARCH) && (iss_ff != count_ff);

   // status of the latched command against the pre-step state
   always_comb begin
      status = STS_DONE;
      case (cmd_ff) inside
         CMD_ENQ: begin
            if (full_ff) status = STS_FULL;
         end
         CMD_DEQ, CMD_REPL: begin
            if (!nonempty) status = STS_EMPTY;
         end
         default: status = STS_DONE;
      endcase
   end

   // store write: enqueue at tail, replace at the slot before tail
   assign do_write = (state_ff == ST_UPDATE) && out_free && (status == STS_DONE) &&
                     ((cmd_ff == CMD_ENQ) || (cmd_ff == CMD_REPL));
   assign ram_wr.en   = do_write;
   assign ram_wr.addr = (cmd_ff == CMD_ENQ) ? tail_ff : slot_prev(tail_ff);
   assign ram_wr.data = key_ff;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      full_in       = full_ff;
      pos_in        = pos_ff;
      iss_in        = iss_ff;
      pend_in       = 1'b0;
      first_in      = first_ff;
      found_in      = found_ff;
      front_in      = front_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_fvalid_in = rsp_fvalid_ff;
      rsp_fdata_in  = rsp_fdata_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_full_in   = rsp_full_ff;
      rsp_found_in  = rsp_found_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               // snapshot the word and the full flag, search starts at head
               cmd_in   = req_command;
               key_in   = req_data;
               full_in  = full_now;
               pos_in   = head_ff;
               iss_in   = '0;
               first_in = 1'b1;
               found_in = 1'b0;
               front_in = 8'd0;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            // issue one read a cycle, compare the byte read last cycle
            if (rd_en) begin
               pos_in  = slot_next(pos_ff);
               iss_in  = iss_ff + CNT_W'(1);
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               if (rd_data == key_ff) found_in = 1'b1;
               // first byte read is the head entry
               if (first_ff) begin
                  front_in = rd_data;
                  first_in = 1'b0;
               end
            end
            if (!rd_en) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status;
               rsp_fvalid_in = nonempty;
               rsp_fdata_in  = front_ff;
               rsp_occ_in    = 5'(count_ff);
               rsp_full_in   = full_ff;
               rsp_found_in  = found_ff;
               if (status == STS_DONE) begin
                  if (cmd_ff == CMD_ENQ) begin
                     tail_in  = slot_next(tail_ff);
                     count_in = count_ff + CNT_W'(1);
                  end else if (cmd_ff == CMD_DEQ) begin
                     head_in  = slot_next(head_ff);
                     count_in = count_ff - CNT_W'(1);
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         if (csr_wr_en) cap_ff <= csr_wr_data;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      full_ff       <= full_in;
      pos_ff        <= pos_in;
      iss_ff        <= iss_in;
      first_ff      <= first_in;
      found_ff      <= found_in;
      front_ff      <= front_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fvalid_ff <= rsp_fvalid_in;
      rsp_fdata_ff  <= rsp_fdata_in;
      rsp_occ_ff    <= rsp_occ_in;
      rsp_full_ff   <= rsp_full_in;
      rsp_found_ff  <= rsp_found_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_front_valid = rsp_fvalid_ff;
   assign rsp_front_data  = rsp_fdata_ff;
   assign rsp_occupancy   = rsp_occ_ff;
   assign rsp_full_flag   = rsp_full_ff;
   assign rsp_key_found   = rsp_found_ff;

`include "searchable_bounded_fifo_assert.svh"

   // count never passes the store depth
   `SBF_ASSERT_NOW(a_count_max, 1'b1, count_ff <= CNT_W'(DEPTH))
   // empty or completely full queue has head and tail on the same slot
   `SBF_ASSERT_NOW(a_ptr_match, (count_ff == '0) || (count_ff == CNT_W'(DEPTH)), head_ff == tail_ff)
   // a read issued in search is compared in the next cycle
   `SBF_ASSERT_NEXT(a_read_cmp, rd_en, pend_ff && (state_ff == ST_SEARCH))
   // no compare is left pending when the sequencer is idle
   `SBF_ASSERT_NOW(a_idle_quiet, state_ff == ST_IDLE, !pend_ff)
   // store is written only in the update cycle that loads a result
   `SBF_ASSERT_NEXT(a_write_rsp, ram_wr.en, rsp_valid_ff && (state_ff == ST_IDLE))

endmodule
